// ----- rtl/ted_pkg.sv -----
// Package: shared constants, state codes and types for the terminal key escape decoder.
`default_nettype none

package ted_pkg;

    // Characters that steer the sequence decoder
    localparam logic [7:0] CHAR_ESC   = 8'd27;
    localparam logic [7:0] CHAR_LBRK  = 8'h5B; // '['
    localparam logic [7:0] CHAR_O     = 8'h4F; // 'O'
    localparam logic [7:0] CHAR_TILDE = 8'h7E; // '~'
    localparam logic [7:0] CHAR_TWO   = 8'h32; // '2'
    localparam logic [7:0] CHAR_THREE = 8'h33; // '3'
    localparam logic [7:0] CHAR_ONE   = 8'h31; // '1'
    localparam logic [7:0] CHAR_COLON = 8'h3A; // ':'
    localparam logic [7:0] CHAR_P     = 8'h50; // 'P'
    localparam logic [7:0] CHAR_Y     = 8'h59; // 'Y'
    localparam logic [7:0] CHAR_A     = 8'h41; // 'A'
    localparam logic [7:0] CHAR_B     = 8'h42; // 'B'
    localparam logic [7:0] CHAR_C     = 8'h43; // 'C'
    localparam logic [7:0] CHAR_D     = 8'h44; // 'D'
    localparam logic [7:0] CHAR_F     = 8'h46; // 'F'
    localparam logic [7:0] CHAR_H     = 8'h48; // 'H'

    // Sequence state codes
    localparam int unsigned ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_ESC  = 3'd1;
    localparam logic [ST_W-1:0] ST_CSI  = 3'd2;
    localparam logic [ST_W-1:0] ST_SS3  = 3'd3;
    localparam logic [ST_W-1:0] ST_CSI2 = 3'd4;
    localparam logic [ST_W-1:0] ST_CSI3 = 3'd5;

    // Special key codes
    localparam logic [7:0] KEY_INS   = 8'd0;
    localparam logic [7:0] KEY_DEL   = 8'd1;
    localparam logic [7:0] KEY_UP    = 8'd2;
    localparam logic [7:0] KEY_DOWN  = 8'd3;
    localparam logic [7:0] KEY_LEFT  = 8'd4;
    localparam logic [7:0] KEY_RIGHT = 8'd5;
    localparam logic [7:0] KEY_HOME  = 8'd6;
    localparam logic [7:0] KEY_END   = 8'd7;
    localparam logic [7:0] KEY_F1    = 8'd8;
    localparam logic [7:0] KEY_F10   = 8'd17;

    // Decode outcome for one byte
    typedef struct packed {
        logic            emit;
        logic            is_special;
        logic [7:0]      key_code;
        logic [ST_W-1:0] next_state;
    } dec_result_t;

endpackage

`default_nettype wire

// ----- rtl/ted_decode.sv -----
// Combinational next-state and key decode for one received byte.
`default_nettype none

module ted_decode (
    input  wire logic [ted_pkg::ST_W-1:0] state,
    input  wire logic [7:0]               rx_byte,
    output ted_pkg::dec_result_t          result
);

    always_comb
    begin
        result            = '0;
        result.next_state = ted_pkg::ST_IDLE;
        if (rx_byte == ted_pkg::CHAR_ESC)
        begin
            // ESC restarts a sequence from any state
            result.next_state = ted_pkg::ST_ESC;
        end
        else
        begin
            unique case (state)
                ted_pkg::ST_ESC:
                begin
                    if (rx_byte == ted_pkg::CHAR_LBRK)
                        result.next_state = ted_pkg::ST_CSI;
                    else if (rx_byte == ted_pkg::CHAR_O)
                        result.next_state = ted_pkg::ST_SS3;
                end
                ted_pkg::ST_CSI:
                begin
                    result.is_special = 1'b1;
                    case (rx_byte)
                        ted_pkg::CHAR_TWO:   result.next_state = ted_pkg::ST_CSI2;
                        ted_pkg::CHAR_THREE: result.next_state = ted_pkg::ST_CSI3;
                        ted_pkg::CHAR_A:
                        begin
                            result.emit = 1'b1; result.key_code = ted_pkg::KEY_UP;
                        end
                        ted_pkg::CHAR_B:
                        begin
                            result.emit = 1'b1; result.key_code = ted_pkg::KEY_DOWN;
                        end
                        ted_pkg::CHAR_C:
                        begin
                            result.emit = 1'b1; result.key_code = ted_pkg::KEY_RIGHT;
                        end
                        ted_pkg::CHAR_D:
                        begin
                            result.emit = 1'b1; result.key_code = ted_pkg::KEY_LEFT;
                        end
                        ted_pkg::CHAR_F:
                        begin
                            result.emit = 1'b1; result.key_code = ted_pkg::KEY_END;
                        end
                        ted_pkg::CHAR_H:
                        begin
                            result.emit = 1'b1; result.key_code = ted_pkg::KEY_HOME;
                        end
                        default: ;
                    endcase
                end
                ted_pkg::ST_SS3:
                begin
                    result.is_special = 1'b1;
                    // F1-F10 from '1'..':' or 'P'..'Y'
                    if (rx_byte >= ted_pkg::CHAR_ONE && rx_byte <= ted_pkg::CHAR_COLON)
                    begin
                        result.emit     = 1'b1;
                        result.key_code = ted_pkg::KEY_F1 + (rx_byte - ted_pkg::CHAR_ONE);
                    end
                    else if (rx_byte >= ted_pkg::CHAR_P && rx_byte <= ted_pkg::CHAR_Y)
                    begin
                        result.emit     = 1'b1;
                        result.key_code = ted_pkg::KEY_F1 + (rx_byte - ted_pkg::CHAR_P);
                    end
                end
                ted_pkg::ST_CSI2:
                begin
                    result.is_special = 1'b1;
                    result.key_code   = ted_pkg::KEY_INS;
                    result.emit       = (rx_byte == ted_pkg::CHAR_TILDE);
                end
                ted_pkg::ST_CSI3:
                begin
                    result.is_special = 1'b1;
                    result.key_code   = ted_pkg::KEY_DEL;
                    result.emit       = (rx_byte == ted_pkg::CHAR_TILDE);
                end
                default:
                begin
                    // idle, and unused codes behave as idle: plain pass-through
                    result.emit     = 1'b1;
                    result.key_code = rx_byte;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/terminal_key_escape_decoder_top.sv -----
// Top level: terminal key escape decoder with input and result registers.
//
// Usage:
//   Input channel (rx_byte, in_valid/in_ready) takes one terminal byte per
//   transaction. Result channel (is_special, key_code, out_valid/out_ready)
//   gives zero or one result per input byte. Plain bytes come back with
//   is_special = 0; completed ESC [ / ESC O sequences give is_special = 1 and
//   a key code (0 ins, 1 del, 2 up, 3 down, 4 left, 5 right, 6 home, 7 end,
//   8-17 F1-F10). ESC and bytes inside an unfinished sequence give no result.
//   Timing: a byte accepted into the input register is decoded and lands in
//   the result register once that register is not stalled; its result, if any,
//   then shows on out_valid and is taken while out_ready is high.
//   Throughput: one byte per cycle while the result register is not stalled;
//   the sequence state register is the only loop.
//   Stall: when a result waits on out_ready low, the input register still
//   takes one more byte; only when both registers are full does in_ready drop.
//   Reset (rst_n low, asynchronous): both registers empty, sequence idle.
`default_nettype none

module terminal_key_escape_decoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] rx_byte,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            is_special,
    output logic [7:0]      key_code,
    output logic            out_valid,
    input  wire logic       out_ready
);

    logic                         in_full_reg;
    logic                         in_full_next;
    logic [7:0]                   in_byte_reg;
    logic [ted_pkg::ST_W-1:0]     state_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_special_reg;
    logic [7:0]                   out_code_reg;
    logic                         stall;
    logic                         advance;
    logic                         in_fire;
    ted_pkg::dec_result_t         dec;

    // Result register blocked by the receiver
    assign stall    = out_valid_reg && !out_ready;
    // Held byte moves through the decoder into the result register
    assign advance  = in_full_reg && !stall;
    assign in_ready = !in_full_reg || !stall;
    assign in_fire  = in_valid && in_ready;

    ted_decode u_decode (
        .state   (state_reg),
        .rx_byte (in_byte_reg),
        .result  (dec)
    );

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_fire)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = dec.emit;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ted_pkg::ST_IDLE;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= dec.next_state;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_byte_reg <= rx_byte;
        if (advance && dec.emit)
        begin
            out_special_reg <= dec.is_special;
            out_code_reg    <= dec.key_code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_special = out_special_reg;
    assign key_code   = out_code_reg;

endmodule

`default_nettype wire

// ----- rtl/ted_checker.sv -----
// Checker: port-level assertions for the terminal key escape decoder, bound to the top level.
`default_nettype none

module ted_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       is_special,
    input wire logic [7:0] key_code,
    input wire logic       out_valid,
    input wire logic       out_ready
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_special) && $stable(key_code))
        else $error("result changed while stalled");

    // Input backpressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without a stalled result");

    // Decoded keys stay within the key table
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_special |-> key_code <= ted_pkg::KEY_F10)
        else $error("special key code out of range");

    // ESC never passes through as a plain byte
    a_no_plain_esc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_special |-> key_code != ted_pkg::CHAR_ESC)
        else $error("ESC emitted as plain byte");

    // Input side observed for completeness of the port view
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$isunknown(in_ready))
        else $error("in_ready unknown after transaction");

endmodule

bind terminal_key_escape_decoder_top ted_checker u_ted_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .is_special (is_special),
    .key_code   (key_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
);

`default_nettype wire
